[rtl/core/twcr_pkg.sv]
// Shared types, widths and codes for the textured wall column renderer.
package twcr_pkg;

	localparam int ROW_W      = 9;
	localparam int COL_W      = 10;
	localparam int ADDR_W     = 12;
	localparam int TEXEL_W    = 32;
	localparam int COLOR_W    = 24;
	localparam int DIST_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int POS_W      = 32;
	localparam int TEXCOL_W   = 8;
	localparam int DIV_NW     = 25;
	localparam int DIV_DW     = 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 56;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_ROW   = 2'd2;

	localparam logic [1:0] REGION_CEILING = 2'd0;
	localparam logic [1:0] REGION_WALL    = 2'd1;
	localparam logic [1:0] REGION_FLOOR   = 2'd2;

	localparam logic CFG_CEILING = 1'b0;
	localparam logic CFG_FLOOR   = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_COLUMN,
		KIND_ROW
	} kind_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [ADDR_W-1:0]  texel_index;
		logic [TEXEL_W-1:0] texel_value;
		logic [COL_W-1:0]   screen_column;
		logic [DIST_W-1:0]  wall_distance;
		logic [FRAC_W-1:0]  wall_hit_fraction;
		logic               wall_side;
		logic               ray_x_positive;
		logic               ray_y_negative;
	} req_t;

	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   tex_addr;
		logic [TEXEL_W-1:0]  tex_value;
		logic [ROW_W-1:0]    start_row;
		logic [ROW_W-1:0]    end_row;
		logic [TEXCOL_W-1:0] tex_col;
		logic [POS_W-1:0]    tex_pos;
		logic [POS_W-1:0]    tex_step;
		logic [COL_W-1:0]    column;
	} entry_t;

endpackage

[rtl/core/twcr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module twcr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [twcr_pkg::DIV_NW-1:0]      dividend,
	input  logic [twcr_pkg::DIV_DW-1:0]      divisor,
	output logic                             done,
	output logic [twcr_pkg::DIV_NW-1:0]      quotient
);
	import twcr_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   rem_sub;
	logic              ge;

	// quo_q shifts the dividend out at the top and the quotient in at the bottom
	assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW - 1);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/twcr_front.sv]
// Front end: accepts requests, runs column setup and queues work for the back end.
module twcr_front #(
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH     = 64,
	parameter int TEX_HEIGHT    = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  twcr_pkg::req_t   in_req,
	output logic             push,
	output twcr_pkg::entry_t push_entry,
	input  logic             q_full
);
	import twcr_pkg::*;

	localparam int LTW = $clog2(TEX_WIDTH);
	localparam logic [DIV_NW-1:0] LINE_NUM = DIV_NW'(SCREEN_HEIGHT * 256);
	localparam logic [DIV_NW-1:0] STEP_NUM = DIV_NW'(TEX_HEIGHT * 65536);
	localparam logic [DIV_DW-1:0] HALF_H   = DIV_DW'(SCREEN_HEIGHT / 2);
	localparam logic [DIV_DW-1:0] H_FULL   = DIV_DW'(SCREEN_HEIGHT);
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_LINE,
		ST_DIV_STEP,
		ST_MUL,
		ST_PUSH
	} state_t;

	state_t                  state_q;
	logic [COL_W-1:0]        column_q;
	logic [LTW-1:0]          texcol_q;
	logic [ROW_W-1:0]        start_q;
	logic [ROW_W-1:0]        end_q;
	logic [DIST_W-1:0]       offset_q;
	logic [DIV_NW-1:0]       step_q;
	logic [POS_W-1:0]        pos_q;

	logic                    accept;
	logic                    div_start;
	logic                    div_done;
	logic [DIV_NW-1:0]       div_dividend;
	logic [DIV_DW-1:0]       div_divisor;
	logic [DIV_NW-1:0]       div_quo;
	logic [DIV_DW-1:0]       depth_c;
	logic [DIV_DW-1:0]       line_c;
	logic [DIV_DW-1:0]       half_c;
	logic [DIV_DW-1:0]       end_sum_c;
	logic [ROW_W-1:0]        start_c;
	logic [ROW_W-1:0]        end_c;
	logic [DIST_W-1:0]       offset_c;
	logic [LTW-1:0]          tex_raw_c;
	logic [LTW-1:0]          texcol_c;
	logic                    mirror_c;
	logic [DIST_W+DIV_NW-1:0] prod_c;

	assign in_ready = (state_q == ST_IDLE) && !q_full;
	assign accept   = in_valid && in_ready;

	// a zero distance counts as one LSB
	assign depth_c = (in_req.wall_distance == '0) ? DIV_DW'(1) : {1'b0, in_req.wall_distance};

	assign tex_raw_c = in_req.wall_hit_fraction[FRAC_W-1 -: LTW];
	assign mirror_c  = (!in_req.wall_side && in_req.ray_x_positive) ||
		(in_req.wall_side && in_req.ray_y_negative);
	assign texcol_c  = mirror_c ? ~tex_raw_c : tex_raw_c;

	assign line_c    = div_quo[DIV_DW-1:0];
	assign half_c    = {1'b0, line_c[DIV_DW-1:1]};
	assign start_c   = (half_c >= HALF_H) ? '0 : ROW_W'(HALF_H - half_c);
	assign end_sum_c = HALF_H + half_c;
	assign end_c     = (end_sum_c >= H_FULL) ? LAST_ROW : end_sum_c[ROW_W-1:0];
	// rows of the wall clipped off above the screen
	assign offset_c  = (half_c > HALF_H) ? DIST_W'(half_c - HALF_H) : '0;

	assign prod_c = offset_q * step_q;

	assign div_start = (accept && in_req.command == CMD_START) ||
		(state_q == ST_DIV_LINE && div_done && line_c != '0);
	assign div_dividend = (state_q == ST_IDLE) ? LINE_NUM : STEP_NUM;
	assign div_divisor  = (state_q == ST_IDLE) ? depth_c : line_c;

	twcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign push = (accept && (in_req.command == CMD_LOAD || in_req.command == CMD_ROW)) ||
		(state_q == ST_PUSH && !q_full);

	always_comb begin
		push_entry           = '0;
		push_entry.tex_addr  = in_req.texel_index;
		push_entry.tex_value = in_req.texel_value;
		if (state_q == ST_PUSH) begin
			push_entry.kind      = KIND_COLUMN;
			push_entry.start_row = start_q;
			push_entry.end_row   = end_q;
			push_entry.tex_col   = TEXCOL_W'(texcol_q);
			push_entry.tex_pos   = pos_q;
			push_entry.tex_step  = POS_W'(step_q);
			push_entry.column    = column_q;
		end else if (in_req.command == CMD_LOAD) begin
			push_entry.kind = KIND_LOAD;
		end else begin
			push_entry.kind = KIND_ROW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			column_q <= '0;
			texcol_q <= '0;
			start_q  <= '0;
			end_q    <= '0;
			offset_q <= '0;
			step_q   <= '0;
			pos_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_req.command == CMD_START) begin
						column_q <= in_req.screen_column;
						texcol_q <= texcol_c;
						state_q  <= ST_DIV_LINE;
					end
				end
				ST_DIV_LINE: begin
					if (div_done) begin
						start_q  <= start_c;
						end_q    <= end_c;
						offset_q <= offset_c;
						step_q   <= '0;
						// zero line height: no step division, step stays zero
						state_q  <= (line_c == '0) ? ST_MUL : ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					if (div_done) begin
						step_q  <= div_quo;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					pos_q   <= prod_c[POS_W-1:0];
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/twcr_fifo.sv]
// Small queue of work entries between the front and back ends.
module twcr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  twcr_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output twcr_pkg::entry_t head,
	output logic             nempty
);
	import twcr_pkg::*;

	entry_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = count_q == FIFO_CW'(FIFO_DEPTH);
	assign nempty  = count_q != '0;
	assign do_push = push && !full;
	assign do_pop  = pop && nempty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/twcr_back.sv]
// Back end: texture store, column walk and pixel output register.
module twcr_back #(
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH     = 64,
	parameter int TEX_HEIGHT    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  twcr_pkg::entry_t               q_entry,
	input  logic [twcr_pkg::COLOR_W-1:0]   ceiling_color,
	input  logic [twcr_pkg::COLOR_W-1:0]   floor_color,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [twcr_pkg::TEXEL_W-1:0]   out_color,
	output logic [twcr_pkg::ROW_W-1:0]     out_row,
	output logic [twcr_pkg::COL_W-1:0]     out_column,
	output logic [1:0]                     out_region,
	output logic                           out_last
);
	import twcr_pkg::*;

	localparam int LTW         = $clog2(TEX_WIDTH);
	localparam int LTH         = $clog2(TEX_HEIGHT);
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

	logic [TEXEL_W-1:0] tex_mem [STORE_DEPTH];
	logic [TEXEL_W-1:0] rd_q;

	logic               active_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   start_q;
	logic [ROW_W-1:0]   end_q;
	logic [LTW-1:0]     texcol_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   step_q;
	logic [COL_W-1:0]   column_q;

	logic               v_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]   column_s1;
	logic [1:0]         region_s1;
	logic               last_s1;

	logic               out_valid_q;
	logic [TEXEL_W-1:0] color_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_column_q;
	logic [1:0]         region_q;
	logic               last_q;

	logic               out_free;
	logic               s1_adv;
	logic               s1_free;
	logic               emit;
	logic [1:0]         region_c;
	logic               last_c;
	logic [LTH-1:0]     texy_c;
	logic [LTH+LTW+ADDR_W-1:0] addr_ext_c;
	logic [ADDR_W-1:0]  rd_addr_c;

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = v_s1 && out_free;
	assign s1_free  = !v_s1 || s1_adv;
	assign q_pop    = q_valid && s1_free;
	assign emit     = q_pop && q_entry.kind == KIND_ROW && active_q;

	always_comb begin
		if (row_q < start_q) begin
			region_c = REGION_CEILING;
		end else if (row_q < end_q) begin
			region_c = REGION_WALL;
		end else begin
			region_c = REGION_FLOOR;
		end
	end

	assign last_c = row_q >= LAST_ROW;

	// texel address is row * width + column, wrapped to the store size
	assign texy_c     = pos_q[16 +: LTH];
	assign addr_ext_c = {{ADDR_W{1'b0}}, texy_c, texcol_q};
	assign rd_addr_c  = addr_ext_c[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.kind == KIND_LOAD) begin
			tex_mem[q_entry.tex_addr] <= q_entry.tex_value;
		end
		if (emit) begin
			rd_q <= tex_mem[rd_addr_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
			start_q  <= '0;
			end_q    <= '0;
			texcol_q <= '0;
			pos_q    <= '0;
			step_q   <= '0;
			column_q <= '0;
		end else if (q_pop) begin
			case (q_entry.kind)
				KIND_COLUMN: begin
					// a new column drops any column still in progress
					active_q <= 1'b1;
					row_q    <= '0;
					start_q  <= q_entry.start_row;
					end_q    <= q_entry.end_row;
					texcol_q <= q_entry.tex_col[LTW-1:0];
					pos_q    <= q_entry.tex_pos;
					step_q   <= q_entry.tex_step;
					column_q <= q_entry.column;
				end
				KIND_ROW: begin
					if (active_q) begin
						if (last_c) begin
							active_q <= 1'b0;
						end else begin
							row_q <= row_q + ROW_W'(1);
						end
						if (region_c == REGION_WALL) begin
							pos_q <= pos_q + step_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= emit;
			end
			if (out_free) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_s1    <= row_q;
			column_s1 <= column_q;
			region_s1 <= region_c;
			last_s1   <= last_c;
		end
		if (s1_adv) begin
			out_row_q    <= row_s1;
			out_column_q <= column_s1;
			region_q     <= region_s1;
			last_q       <= last_s1;
			case (region_s1)
				REGION_WALL:    color_q <= rd_q;
				REGION_CEILING: color_q <= {8'h00, ceiling_color};
				default:        color_q <= {8'h00, floor_color};
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_color  = color_q;
	assign out_row    = out_row_q;
	assign out_column = out_column_q;
	assign out_region = region_q;
	assign out_last   = last_q;

endmodule

[rtl/core/textured_wall_column_renderer_unit.sv]
// Textured wall column renderer: one screen column of a raycaster per start request.
//
// Requests enter on s_axis; tuser carries the command (load texel, start column,
// next row). A load writes one texel of the texture store and gives no pixel. A start
// brings the wall distance and hit point; setup runs two 25-step divisions on one
// bit-serial divider plus a multiply, so the input stalls after a start until the
// column is queued (the second division is skipped when the line height is zero).
// Each next-row request gives one pixel on m_axis, top row first: ceiling color, then
// texels, then floor color; tlast marks the bottom row, after which next-row requests
// are dropped until the next start. Next-row and load requests are taken one per cycle
// while setup is idle and the queue has room; each pixel leaves from the output register.
// A four-entry queue separates setup from the pixel path, so the input keeps
// flowing while m_axis is stalled until that queue fills; pixels are never dropped.
// Write ceiling_color and floor_color on the cfg channel while the block is idle.
// Reset clears the column state and both colors; the texture store holds whatever
// was last written and must be loaded before use.
module textured_wall_column_renderer_unit #(
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH     = 64,
	parameter int TEX_HEIGHT    = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tdata: texel_index, texel_value, screen_column, wall_distance,
	//        wall_hit_fraction, wall_side, ray_x_positive, ray_y_negative
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [twcr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// tuser: command
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: pixel_color, pixel_row, pixel_column
	output logic [twcr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// tuser: region
	output logic [1:0]                       m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [twcr_pkg::COLOR_W-1:0]     cfg_data
);
	import twcr_pkg::*;

	req_t               req;
	entry_t             push_entry;
	entry_t             head;
	logic               push;
	logic               q_full;
	logic               q_nempty;
	logic               q_pop;
	logic [COLOR_W-1:0] ceiling_q;
	logic [COLOR_W-1:0] floor_q;
	logic [TEXEL_W-1:0] pix_color;
	logic [ROW_W-1:0]   pix_row;
	logic [COL_W-1:0]   pix_column;

	assign req.command           = s_axis_tuser;
	assign req.texel_index       = s_axis_tdata[11:0];
	assign req.texel_value       = s_axis_tdata[43:12];
	assign req.screen_column     = s_axis_tdata[53:44];
	assign req.wall_distance     = s_axis_tdata[69:54];
	assign req.wall_hit_fraction = s_axis_tdata[85:70];
	assign req.wall_side         = s_axis_tdata[86];
	assign req.ray_x_positive    = s_axis_tdata[87];
	assign req.ray_y_negative    = s_axis_tdata[88];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= '0;
			floor_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CEILING: ceiling_q <= cfg_data;
				CFG_FLOOR:   floor_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	twcr_front #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEX_WIDTH     (TEX_WIDTH),
		.TEX_HEIGHT    (TEX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_req     (req),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	twcr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.nempty     (q_nempty)
	);

	twcr_back #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEX_WIDTH     (TEX_WIDTH),
		.TEX_HEIGHT    (TEX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_nempty),
		.q_pop         (q_pop),
		.q_entry       (head),
		.ceiling_color (ceiling_q),
		.floor_color   (floor_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_color     (pix_color),
		.out_row       (pix_row),
		.out_column    (pix_column),
		.out_region    (m_axis_tuser),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, pix_column, pix_row, pix_color};

endmodule

[rtl/core/twcr_checker.sv]
// Port-level checks on the pixel output of the renderer, bound to the top level.
module twcr_checker #(
	parameter int SCREEN_HEIGHT = 480
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [twcr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);
	import twcr_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

	// hold a stalled pixel
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("pixel changed while stalled");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[40:32] == LAST_ROW))
		else $error("tlast does not match the bottom row");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[40:32] <= LAST_ROW)
		else $error("pixel row beyond screen");

	// ceiling and floor pixels carry zero alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != REGION_WALL |-> m_axis_tdata[31:24] == 8'h00)
		else $error("non-wall pixel with nonzero alpha");

endmodule

bind textured_wall_column_renderer_unit twcr_checker #(
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_twcr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

[tb/textured_wall_column_renderer_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the textured wall column renderer: random stimulus, stalls, pixel checks.
module textured_wall_column_renderer_unit_test;
	import twcr_pkg::*;

	localparam int SCREEN_ROWS = 480;
	localparam int TEX_W = 64;
	localparam int TEX_H = 64;
	localparam int REQ_BITS = 89;
	localparam int SETUP_CYCLES = 80;
	localparam int MAX_REPORTS = 10;
	localparam int FILLED_COLUMNS = 2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] color;
		logic [8:0]  row;
		logic [9:0]  column;
		logic [1:0]  region;
		logic        bottom;
	} pixel_t;

	class pixel_scoreboard;
		logic [COLOR_W-1:0] ceiling_rgb;
		logic [COLOR_W-1:0] floor_rgb;
		logic [TEXEL_W-1:0] texels [4096];
		int row_count, wall_top, wall_bottom, tex_col;
		logic [31:0] tex_pos, tex_step;
		logic [9:0] column;
		bit active;
		pixel_t pending_pixels[$];
		int mismatches, requests_seen, pixels_checked, bottom_rows;
		int region_count [3];

		function new();
			ceiling_rgb = '0;
			floor_rgb = '0;
			foreach (texels[i]) texels[i] = '0;
			row_count = 0;
			wall_top = 0;
			wall_bottom = 0;
			tex_col = 0;
			tex_pos = '0;
			tex_step = '0;
			column = '0;
			active = 0;
			mismatches = 0;
			requests_seen = 0;
			pixels_checked = 0;
			bottom_rows = 0;
			foreach (region_count[i]) region_count[i] = 0;
		endfunction

		function void note_config(logic idx, logic [COLOR_W-1:0] rgb);
			if (idx == CFG_CEILING)
				ceiling_rgb = rgb;
			else
				floor_rgb = rgb;
		endfunction

		function void note_request(logic [1:0] cmd, logic [S_TDATA_W-1:0] data);
			pixel_t px;
			int d, line_h, offset, texy;
			longint stp;
			logic [15:0] frac;
			requests_seen++;
			case (cmd)
				CMD_LOAD: texels[data[11:0]] = data[43:12];
				CMD_START: begin
					d = int'(data[69:54]);
					if (d == 0) d = 1;
					line_h = SCREEN_ROWS * 256 / d;
					wall_top = SCREEN_ROWS / 2 - line_h / 2;
					if (wall_top < 0) wall_top = 0;
					wall_bottom = SCREEN_ROWS / 2 + line_h / 2;
					if (wall_bottom >= SCREEN_ROWS) wall_bottom = SCREEN_ROWS - 1;
					stp = (line_h > 0) ? longint'(TEX_H) * 65536 / line_h : 0;
					offset = wall_top - SCREEN_ROWS / 2 + line_h / 2;
					if (offset < 0) offset = 0;
					frac = data[85:70];
					tex_col = (int'(frac) * TEX_W) >> 16;
					// mirror for rays seen from the far side of the wall
					if ((!data[86] && data[87]) || (data[86] && data[88]))
						tex_col = TEX_W - 1 - tex_col;
					tex_step = stp[31:0];
					tex_pos = 32'(longint'(offset) * stp);
					column = data[53:44];
					row_count = 0;
					active = 1;
				end
				CMD_ROW: if (active) begin
					px.row = row_count[8:0];
					px.column = column;
					px.bottom = (row_count >= SCREEN_ROWS - 1);
					if (row_count < wall_top) begin
						px.color = {8'h00, ceiling_rgb};
						px.region = REGION_CEILING;
					end else if (row_count < wall_bottom) begin
						texy = int'(tex_pos >> 16) & (TEX_H - 1);
						px.color = texels[12'(texy * TEX_W + tex_col)];
						tex_pos = tex_pos + tex_step;
						px.region = REGION_WALL;
					end else begin
						// the clamped end row falls here too
						px.color = {8'h00, floor_rgb};
						px.region = REGION_FLOOR;
					end
					pending_pixels.push_back(px);
					if (px.bottom)
						active = 0;
					else
						row_count++;
				end
				default: ;
			endcase
		endfunction

		function void check_pixel(logic [M_TDATA_W-1:0] data, logic [1:0] user, logic tlast);
			pixel_t got, want;
			got.color = data[31:0];
			got.row = data[40:32];
			got.column = data[50:41];
			got.region = user;
			got.bottom = tlast;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected pixel: color %h row %0d column %0d region %0d last %0b",
						got.color, got.row, got.column, got.region, got.bottom);
				return;
			end
			want = pending_pixels.pop_front();
			pixels_checked++;
			if (got.color !== want.color || got.row !== want.row || got.column !== want.column ||
				got.region !== want.region || got.bottom !== want.bottom) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("pixel mismatch: expected color %h row %0d column %0d region %0d last %0b",
						want.color, want.row, want.column, want.region, want.bottom);
					$display("                got      color %h row %0d column %0d region %0d last %0b",
						got.color, got.row, got.column, got.region, got.bottom);
				end
			end else begin
				region_count[want.region]++;
				bottom_rows += want.bottom;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [COLOR_W-1:0] cfg_data;

	pixel_scoreboard sb;
	bit input_calm;
	bit ready_calm;
	int calm_left;
	int stall_left;
	int stall_roll;
	int live_items;
	int loaded_cols[$];
	bit col_loaded [TEX_W];

	textured_wall_column_renderer_unit #(
		.SCREEN_HEIGHT(SCREEN_ROWS),
		.TEX_WIDTH(TEX_W),
		.TEX_HEIGHT(TEX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tuser, s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// output back-pressure: calm stretches, short stalls, now and then a long one
	always @(posedge clk) begin
		if (calm_left == 0) begin
			ready_calm = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(50, 400);
		end else
			calm_left--;
		if (stall_left == 0 && !ready_calm) begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 3)
				stall_left = $urandom_range(10, 40);
			else if (stall_roll < 25)
				stall_left = $urandom_range(1, 3);
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else
			m_axis_tready <= 1'b1;
	end

	function automatic int pick_gap();
		int r;
		if (input_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 62) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [S_TDATA_W-1:0] random_fields();
		logic [S_TDATA_W-1:0] v;
		v = {$urandom, $urandom, $urandom};
		v[S_TDATA_W-1:REQ_BITS] = '0;
		return v;
	endfunction

	function automatic logic [S_TDATA_W-1:0] load_fields(logic [11:0] idx, logic [31:0] val);
		logic [S_TDATA_W-1:0] v;
		v = random_fields();
		v[11:0] = idx;
		v[43:12] = val;
		return v;
	endfunction

	// pick the hit fraction so that the (possibly mirrored) texture column is tcol
	function automatic logic [S_TDATA_W-1:0] start_fields(logic [9:0] scol, logic [15:0] dist_in,
		int tcol, logic side, logic xpos, logic yneg);
		logic [S_TDATA_W-1:0] v;
		logic [5:0] raw;
		v = random_fields();
		raw = ((!side && xpos) || (side && yneg)) ? 6'(TEX_W - 1 - tcol) : 6'(tcol);
		v[53:44] = scol;
		v[69:54] = dist_in;
		v[85:70] = {raw, 10'($urandom)};
		v[86] = side;
		v[87] = xpos;
		v[88] = yneg;
		return v;
	endfunction

	function automatic logic [15:0] random_distance();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(4, 255));
			2: return 16'($urandom_range(256, 1024));
			3: return 16'($urandom_range(1025, 8000));
			4: return 16'($urandom_range(8001, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(logic [1:0] cmd, logic [S_TDATA_W-1:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic set_colors(logic [COLOR_W-1:0] ceil_rgb, logic [COLOR_W-1:0] floor_rgb);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CEILING;
		cfg_data <= ceil_rgb;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(CFG_CEILING, ceil_rgb);
		cfg_index <= CFG_FLOOR;
		cfg_data <= floor_rgb;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(CFG_FLOOR, floor_rgb);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, drain every expected pixel, then let a column setup finish
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETUP_CYCLES) @(posedge clk);
	endtask

	task automatic run_column(logic [S_TDATA_W-1:0] start_req, int nrows);
		send(CMD_START, start_req);
		live_items++;
		for (int i = 0; i < nrows; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				send(CMD_LOAD, load_fields(12'($urandom), $urandom));
				live_items++;
			end
			send(CMD_ROW, random_fields());
			if (i < SCREEN_ROWS) live_items++;
		end
	endtask

	task automatic random_phase(int target);
		int goal, r, p, nrows;
		goal = live_items + target;
		while (live_items < goal) begin
			input_calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send(CMD_LOAD, load_fields(12'($urandom), $urandom));
				live_items++;
			end else if (r < 10)
				send(CMD_UNUSED, random_fields());
			else begin
				// mostly short columns cut off by the next start, some deeper ones
				p = $urandom_range(0, 99);
				if (p < 75)
					nrows = $urandom_range(1, 30);
				else
					nrows = $urandom_range(40, 80);
				run_column(start_fields(10'($urandom), random_distance(),
					loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
					1'($urandom), 1'($urandom), 1'($urandom)), nrows);
			end
		end
	endtask

	initial begin
		int c;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOAD;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CEILING;
		cfg_data = '0;
		input_calm = 0;
		ready_calm = 0;
		calm_left = 0;
		stall_left = 0;
		live_items = 0;
		foreach (col_loaded[i]) col_loaded[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_colors(24'h000000, 24'hFFFFFF);

		// fill whole texture columns so that wall reads never touch an unwritten texel
		col_loaded[0] = 1;
		col_loaded[TEX_W - 1] = 1;
		loaded_cols.push_back(0);
		loaded_cols.push_back(TEX_W - 1);
		while (loaded_cols.size() < FILLED_COLUMNS) begin
			c = $urandom_range(1, TEX_W - 2);
			if (!col_loaded[c]) begin
				col_loaded[c] = 1;
				loaded_cols.push_back(c);
			end
		end
		foreach (loaded_cols[k])
			for (int r = 0; r < TEX_H; r++)
				send(CMD_LOAD, load_fields(12'(r * TEX_W + loaded_cols[k]), $urandom));

		// directed: dropped requests, texel extremes, distance extremes, mirroring
		send(CMD_ROW, random_fields());
		send(CMD_UNUSED, random_fields());
		send(CMD_LOAD, load_fields(12'hFFF, 32'hFFFF_FFFF));
		send(CMD_LOAD, load_fields(12'h000, 32'h0000_0000));
		run_column(start_fields(10'h3FF, 16'h0000, 0, 1'b1, 1'b1, 1'b1), 3);
		run_column(start_fields(10'h000, 16'hFFFF, TEX_W - 1, 1'b0, 1'b0, 1'b0), 2);
		run_column(start_fields(10'h200, 16'h0100, 0, 1'b0, 1'b1, 1'b0), 2);
		run_column(start_fields(10'h155, 16'h0001, TEX_W - 1, 1'b1, 1'b0, 1'b0), 2);
		run_column(start_fields(10'h2AA, 16'h00FF, 0, 1'b0, 1'b0, 1'b1), 2);
		// one complete column, clipped at the top, with rows past the bottom dropped
		run_column(start_fields(10'h0AB, 16'h00C0, TEX_W - 1, 1'b1, 1'b0, 1'b1),
			SCREEN_ROWS + 2);
		wait_idle();

		random_phase(30);
		wait_idle();
		set_colors(24'hFFFFFF, 24'h000000);
		random_phase(25);
		wait_idle();
		set_colors(24'($urandom), 24'($urandom));
		random_phase(25);
		wait_idle();

		$display("Sent %0d requests (%0d loads, starts and live rows); checked %0d pixels.",
			sb.requests_seen, live_items, sb.pixels_checked);
		$display("Matched ceiling %0d, wall %0d, floor %0d, bottom rows %0d; mismatches %0d.",
			sb.region_count[0], sb.region_count[1], sb.region_count[2], sb.bottom_rows,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("[textured_wall_column_renderer_unit] OK");
		else
			$display("[textured_wall_column_renderer_unit] ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d pixels still expected.", sb.pending_pixels.size());
		$display("[textured_wall_column_renderer_unit] ERROR");
		$finish;
	end

endmodule

[textured_wall_column_renderer_unit.f]
rtl/core/twcr_pkg.sv
rtl/core/twcr_div.sv
rtl/core/twcr_front.sv
rtl/core/twcr_fifo.sv
rtl/core/twcr_back.sv
rtl/core/textured_wall_column_renderer_unit.sv
rtl/core/twcr_checker.sv
tb/textured_wall_column_renderer_unit_test.sv
